// ===== src/slot_allocator_key_map_core_macros.svh =====
// assertion macros shared by the core
`ifndef SLOT_ALLOCATOR_KEY_MAP_CORE_MACROS_SVH
`define SLOT_ALLOCATOR_KEY_MAP_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SKM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skm assertion failed");

// antecedent implies consequent in the next cycle
`define SKM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skm assertion failed");

`endif

// ===== src/skm_pkg.sv =====
package skm_pkg;

   localparam int NUM_SLOTS = 4096;
   localparam int KEY_BITS  = 64;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   localparam int CMD_W    = 2;
   localparam int IN_KEY_W = 64;
   localparam int SLOT_W   = 12;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic clr_en;
      logic start;
      logic scan_en;
      logic commit;
   } skm_cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic out_free;
   } skm_stat_type;

   function automatic logic [SLOT_W-1:0] to_slot_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = (IDX_W+SLOT_W)'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ===== src/skm_req_if.sv =====
interface skm_req_if import skm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [IN_KEY_W-1:0] key;

   modport source (output valid, command, key, input ready);
   modport sink (input valid, command, key, output ready);
endinterface

// ===== src/skm_rsp_if.sv =====
interface skm_rsp_if import skm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   slot_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, slot_index, status, input ready);
   modport sink (input valid, slot_index, status, output ready);
endinterface

// ===== src/skm_ctrl.sv =====
module skm_ctrl import skm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  skm_stat_type stat,
   output skm_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (stat.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.cnt_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== src/skm_datapath.sv =====
`include "slot_allocator_key_map_core_macros.svh"

module skm_datapath import skm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  skm_cmd_type         cmd,
   output skm_stat_type        stat,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [IN_KEY_W-1:0] req_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_slot_index,
   output logic [STATUS_W-1:0] rsp_status
);

   logic [KEY_BITS-1:0] key_mem [NUM_SLOTS];
   logic                used_mem [NUM_SLOTS];

   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                cnt_last;

   logic [CMD_W-1:0]    op_ff;
   logic [KEY_BITS-1:0] key_ff;

   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic                rd_used_ff;
   logic                match;

   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;

   logic [STATUS_W-1:0] res_status;
   logic [IDX_W-1:0]    res_idx;
   logic                wr_key_en;
   logic                wr_used_en;
   logic                wr_used_val;
   logic [IDX_W-1:0]    wr_addr;

   logic                rsp_vld_ff, rsp_vld_in;
   logic [SLOT_W-1:0]   rsp_idx_ff;
   logic [STATUS_W-1:0] rsp_st_ff;

   // slot counter for the clearing pass and the scan
   assign cnt_last = (cnt_ff == IDX_W'(NUM_SLOTS - 1));

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start) begin
         cnt_in = '0;
      end else if (cmd.clr_en || cmd.scan_en) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmd.scan_en;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cnt_ff;
      if (cmd.start) begin
         op_ff  <= req_command;
         key_ff <= req_key[KEY_BITS-1:0];
      end
   end

   // slot stores
   always_ff @(posedge clock) begin
      if (wr_key_en) key_mem[wr_addr] <= key_ff;
      rd_key_ff <= key_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         used_mem[cnt_ff] <= 1'b0;
      end else if (wr_used_en) begin
         used_mem[wr_addr] <= wr_used_val;
      end
      rd_used_ff <= used_mem[cnt_ff];
   end

   // first match and first free slot
   assign match = cmp_vld_ff && rd_used_ff && (rd_key_ff == key_ff);

   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (cmp_vld_ff && !rd_used_ff && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   // result and table update
   always_comb begin
      res_status  = ST_OK;
      res_idx     = '0;
      wr_key_en   = 1'b0;
      wr_used_en  = 1'b0;
      wr_used_val = 1'b0;
      wr_addr     = free_idx_ff;
      case (op_ff)
         CMD_ADD: begin
            if (hit_ff) begin
               res_status = ST_PRESENT;
            end else if (!free_ff) begin
               res_status = ST_FULL;
            end else begin
               res_idx     = free_idx_ff;
               wr_key_en   = cmd.commit;
               wr_used_en  = cmd.commit;
               wr_used_val = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit_ff) begin
               res_idx    = hit_idx_ff;
               wr_addr    = hit_idx_ff;
               wr_used_en = cmd.commit;
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
         default: begin
            // look up, also the unused code
            if (hit_ff) begin
               res_idx = hit_idx_ff;
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (cmd.commit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_idx_ff <= to_slot_index(res_idx);
         rsp_st_ff  <= res_status;
      end
   end

   assign stat.cnt_last  = cnt_last;
   assign stat.out_free  = !rsp_vld_ff || rsp_ready;
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_slot_index = rsp_idx_ff;
   assign rsp_status     = rsp_st_ff;

   `SKM_ASSERT_SAME(a_cmp_follows_read, clock, reset, cmp_vld_ff, $past(cmd.scan_en))
   `SKM_ASSERT_NEXT(a_hit_held, clock, reset, hit_ff && !cmd.start, hit_ff && $stable(hit_idx_ff))
   `SKM_ASSERT_SAME(a_err_idx_zero, clock, reset, rsp_vld_ff && (rsp_st_ff != ST_OK), rsp_idx_ff == '0)

endmodule

// ===== src/slot_allocator_key_map_core.sv =====
// slot allocator with key map
// req_if carries one transaction per request: command (add, remove, look up)
// and key. rsp_if returns one transaction per request: slot_index and status.
// after reset the used flags of all NUM_SLOTS (4096) slots are cleared in a
// single pass; req_if.ready stays low until it is done.
// each request scans every slot through the single read port of the slot
// stores, one slot per cycle, for the first matching key and the first free
// slot. the result is registered in the final step of the request, and the
// table is updated in that same cycle.
// requests are taken one at a time; a new one is accepted while the previous
// result still waits in the output register.
// when the receiver stalls, the result holds in the output register and the
// next result waits in its final step until the register is free.
module slot_allocator_key_map_core import skm_pkg::*; (
   input logic     clock,
   input logic     reset,
   skm_req_if.sink   req_if,
   skm_rsp_if.source rsp_if
);

   skm_cmd_type  cmd;
   skm_stat_type stat;

   skm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   skm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_command    (req_if.command),
      .req_key        (req_if.key),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_slot_index (rsp_if.slot_index),
      .rsp_status     (rsp_if.status)
   );

endmodule

// ===== tb/sv/slot_allocator_key_map_core_tb.sv =====
`timescale 1ns / 1ps

module slot_allocator_key_map_core_tb;
   import skm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP_ALT = 2'd3;
   localparam logic [IN_KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= IN_KEY_W) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);
   localparam int RANDOM_REQS = 118;
   localparam int POOL_SIZE   = 24;
   localparam int DRAIN_WAIT  = NUM_SLOTS + 100;

   typedef struct {
      logic [CMD_W-1:0]    command;
      logic [IN_KEY_W-1:0] key;
      bit                  drain;
   } key_request_type;

   typedef struct {
      logic [SLOT_W-1:0]   slot_index;
      logic [STATUS_W-1:0] status;
   } slot_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   skm_req_if req_chan ();
   skm_rsp_if rsp_chan ();

   slot_allocator_key_map_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   always #6 clock = ~clock;

   key_request_type key_requests[$];
   slot_result_type expected_slots[$];
   bit [IN_KEY_W-1:0] table_key [NUM_SLOTS];
   bit                table_used [NUM_SLOTS];
   bit [IN_KEY_W-1:0] key_pool [POOL_SIZE];

   int error_count = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;
   int req_sent = 0;
   int rsp_seen = 0;
   key_request_type next_req;

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 4);
      return $urandom_range(20, 3000);
   endfunction

   function automatic bit find_slot(input logic [IN_KEY_W-1:0] key, output int slot);
      slot = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (table_used[i] && table_key[i] == key) begin
            slot = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic slot_result_type predict_slot_op(input logic [CMD_W-1:0] command,
                                                       input logic [IN_KEY_W-1:0] raw_key);
      slot_result_type res;
      logic [IN_KEY_W-1:0] key;
      int slot;
      bit hit;
      bit free_found;
      key = raw_key & KEY_MASK;
      res.slot_index = '0;
      res.status = ST_OK;
      hit = find_slot(key, slot);
      if (command == CMD_ADD) begin
         if (hit) begin
            res.status = ST_PRESENT;
         end else begin
            free_found = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!table_used[i] && !free_found) begin
                  free_found = 1'b1;
                  slot = i;
               end
            end
            if (!free_found) begin
               res.status = ST_FULL;
            end else begin
               table_used[slot] = 1'b1;
               table_key[slot] = key;
               res.slot_index = slot[SLOT_W-1:0];
            end
         end
      end else if (command == CMD_REMOVE) begin
         if (hit) begin
            table_used[slot] = 1'b0;
            res.slot_index = slot[SLOT_W-1:0];
         end else begin
            res.status = ST_NOT_FOUND;
         end
      end else begin
         if (hit)
            res.slot_index = slot[SLOT_W-1:0];
         else
            res.status = ST_NOT_FOUND;
      end
      return res;
   endfunction

   function automatic void queue_request(input logic [CMD_W-1:0] command,
                                         input logic [IN_KEY_W-1:0] key,
                                         input bit drain = 1'b0);
      key_request_type r;
      r.command = command;
      r.key = key;
      r.drain = drain;
      key_requests.push_back(r);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (key_requests.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (key_requests[0].drain && expected_slots.size() != 0) begin
            req_chan.valid <= 1'b0;
         end else begin
            next_req = key_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.command <= next_req.command;
            req_chan.key <= next_req.key;
            req_gap <= pick_gap((req_sent % 40) >= 30);
            req_sent <= req_sent + 1;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (rsp_taken) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= pick_gap((rsp_seen % 40) >= 30);
      end else if ($urandom_range(0, 99) < 2) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= pick_gap(1'b0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      slot_result_type exp_res;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      rsp_taken <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_slots.size() == 0) begin
               $error("unexpected result transaction: slot_index %0d status %0d",
                      rsp_chan.slot_index, rsp_chan.status);
               error_count++;
            end else begin
               exp_res = expected_slots.pop_front();
               if (rsp_chan.slot_index !== exp_res.slot_index) begin
                  $error("slot_index mismatch: expected %0d actual %0d",
                         exp_res.slot_index, rsp_chan.slot_index);
                  error_count++;
               end
               if (rsp_chan.status !== exp_res.status) begin
                  $error("status mismatch: expected %0d actual %0d",
                         exp_res.status, rsp_chan.status);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_slots.push_back(predict_slot_op(req_chan.command, req_chan.key));
         end
      end
   end

   initial begin
      logic [IN_KEY_W-1:0] key_a;
      logic [IN_KEY_W-1:0] key;
      logic [CMD_W-1:0] command;
      int r;

      req_chan.valid = 1'b0;
      req_chan.command = CMD_ADD;
      req_chan.key = '0;
      rsp_chan.ready = 1'b0;

      key_a = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = {$urandom, $urandom};

      // directed part
      queue_request(CMD_ADD, '0);
      queue_request(CMD_ADD, '1);
      queue_request(CMD_ADD, '0);
      queue_request(CMD_LOOKUP, '1);
      queue_request(CMD_LOOKUP, '0);
      queue_request(CMD_REMOVE, '0);
      queue_request(CMD_REMOVE, '0);
      queue_request(CMD_LOOKUP, '0);
      queue_request(CMD_ADD, key_a);
      queue_request(CMD_ADD, '0);
      queue_request(CMD_LOOKUP_ALT, '1);
      queue_request(CMD_LOOKUP_ALT, ~key_a);
      queue_request(CMD_REMOVE, '1, 1'b1);
      queue_request(CMD_ADD, key_a ^ 64'd1);
      queue_request(CMD_LOOKUP, key_a ^ {1'b1, 63'd0});
      queue_request(CMD_REMOVE, {1'b1, 63'd0});
      queue_request(CMD_ADD, {1'b1, 63'd0});
      queue_request(CMD_LOOKUP, {1'b0, {63{1'b1}}});
      queue_request(CMD_ADD, {1'b0, {63{1'b1}}});
      queue_request(CMD_LOOKUP, {1'b1, 63'd0});
      queue_request(CMD_REMOVE, key_a);
      queue_request(CMD_LOOKUP, key_a ^ 64'd1);

      // random part over a small key pool so hits and misses both occur
      for (int n = 0; n < RANDOM_REQS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            command = CMD_ADD;
         else if (r < 70)
            command = CMD_REMOVE;
         else if (r < 95)
            command = CMD_LOOKUP;
         else
            command = CMD_LOOKUP_ALT;
         if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            key = {$urandom, $urandom};
         queue_request(command, key, $urandom_range(0, 99) < 3);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (key_requests.size() == 0 && !req_chan.valid && expected_slots.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_slots.size() != 0) begin
         $error("%0d results never arrived", expected_slots.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
